// ===== src/access_unit_boundary_finder_defines.svh =====
// Assertion macros for the access unit boundary finder checker.
// Expects clk and rst_n to be visible where a macro is used.
`ifndef ACCESS_UNIT_BOUNDARY_FINDER_DEFINES_SVH
`define ACCESS_UNIT_BOUNDARY_FINDER_DEFINES_SVH

// checked outside reset only
`define AUBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define AUBF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/aubf_pkg.sv =====
// Shared types and constants of the access unit boundary finder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package aubf_pkg;

  localparam int LEN_BITS    = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int WIN_BYTES   = 6;

  typedef logic [LEN_BITS-1:0] len_t;
  typedef logic [WIN_BYTES-1:0][7:0] window_t;

  // NAL unit types that take part in the boundary rules
  localparam logic [4:0] NAL_NON_IDR = 5'd1;
  localparam logic [4:0] NAL_IDR     = 5'd5;
  localparam logic [4:0] NAL_SPS     = 5'd7;
  localparam logic [4:0] NAL_PPS     = 5'd8;
  localparam logic [4:0] NAL_AUD     = 5'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    len_t unit_length;
    logic found_boundary;
    logic param_set_seen;
    len_t param_set_offset;
    len_t param_set_length;
  } out_item_t;

  // one queued item: the six-byte window ending at this byte and its position
  typedef struct packed {
    window_t win;
    len_t    pos;
    logic    last;
    logic    scan_full;
    logic    scan_tail;
  } entry_t;

endpackage

// ===== src/aubf_front.sv =====
// Front end: takes stream bytes, keeps the byte window and position count,
// and hands one classified entry per byte to the queue. Uses aubf_pkg.
`timescale 1ns / 1ps

module aubf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  aubf_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_wr,
  output aubf_pkg::entry_t  q_entry
);

  localparam aubf_pkg::len_t LEN_MAX = '1;

  aubf_pkg::window_t win_r, win_nxt;
  aubf_pkg::len_t    pos_r, pos_nxt;

  always_comb begin
    for (int i = 0; i < aubf_pkg::WIN_BYTES - 1; i++) begin
      win_nxt[i] = win_r[i+1];
    end
    win_nxt[aubf_pkg::WIN_BYTES-1] = in_data.data_byte;
    // position saturates at the top of its range
    pos_nxt = (pos_r == LEN_MAX) ? pos_r : pos_r + aubf_pkg::len_t'(1);
  end

  assign q_wr = push && !q_full;

  always_comb begin
    q_entry.win       = win_nxt;
    q_entry.pos       = pos_nxt;
    q_entry.last      = in_data.last;
    q_entry.scan_full = pos_nxt >= aubf_pkg::len_t'(6);
    // on the last byte one more position is scanned with a zero byte appended
    q_entry.scan_tail = in_data.last && (pos_nxt >= aubf_pkg::len_t'(5));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      pos_r <= '0;
    end else if (q_wr) begin
      if (in_data.last) begin
        win_r <= '0;
        pos_r <= '0;
      end else begin
        win_r <= win_nxt;
        pos_r <= pos_nxt;
      end
    end
  end

endmodule

// ===== src/aubf_queue.sv =====
// Short register queue between front and back end.
// Holds aubf_pkg::entry_t items; depth set by parameter.
`timescale 1ns / 1ps

module aubf_queue #(
  parameter int DEPTH = aubf_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  aubf_pkg::entry_t wr_data,
  output logic             full,
  output logic             rd_valid,
  input  logic             rd_en,
  output aubf_pkg::entry_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  aubf_pkg::entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full     = count_r == CNT_W'(DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_wr, do_rd})
      2'b10: count_nxt = count_r + CNT_W'(1);
      2'b01: count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== src/aubf_back.sv =====
// Back end: runs the start code scan and boundary rules on queued entries
// and holds the result register. Uses aubf_pkg.
`timescale 1ns / 1ps

module aubf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  aubf_pkg::entry_t    q_entry,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output aubf_pkg::out_item_t out_data
);

  typedef struct packed {
    logic [1:0]     skip;
    logic [1:0]     sps;
    logic [1:0]     pps;
    logic [1:0]     idr;
    logic [1:0]     nonidr;
    logic [1:0]     aud;
    aubf_pkg::len_t sps_start;
    aubf_pkg::len_t sps_span;
  } scan_state_t;

  typedef struct packed {
    scan_state_t st;
    logic        fired;
  } scan_res_t;

  function automatic logic [1:0] sat_inc(input logic [1:0] x);
    return (x == 2'd3) ? x : x + 2'd1;
  endfunction

  // one scan position; w holds the bytes at r .. r+5
  function automatic scan_res_t scan_at(input scan_state_t s, input aubf_pkg::window_t w,
                                        input aubf_pkg::len_t r);
    scan_res_t      res;
    logic           four, three, c;
    logic [4:0]     nal;
    aubf_pkg::len_t payload;
    res.st    = s;
    res.fired = 1'b0;
    four  = (w[0] == 8'h00) && (w[1] == 8'h00) && (w[2] == 8'h00) && (w[3] == 8'h01);
    three = !four && (w[0] == 8'h00) && (w[1] == 8'h00) && (w[2] == 8'h01);
    nal   = four ? w[4][4:0] : w[3][4:0];
    // first_mb_in_slice is zero when its ue(v) code starts with a one
    c     = four ? w[5][7] : w[4][7];
    payload = r + (four ? aubf_pkg::len_t'(4) : aubf_pkg::len_t'(3));
    if (s.skip != 2'd0) begin
      res.st.skip = s.skip - 2'd1;
    end else if (four || three) begin
      case (nal)
        aubf_pkg::NAL_NON_IDR: begin
          res.st.nonidr = sat_inc(s.nonidr);
          res.fired = c && ((s.idr != 2'd0) || (res.st.nonidr >= 2'd2));
        end
        aubf_pkg::NAL_IDR: begin
          res.st.idr = sat_inc(s.idr);
          res.fired = c && ((s.nonidr != 2'd0) || (res.st.idr >= 2'd2));
        end
        aubf_pkg::NAL_SPS: begin
          res.st.sps_start = payload;
          res.st.sps = sat_inc(s.sps);
          res.fired = (s.nonidr != 2'd0) || (s.idr != 2'd0) || (res.st.sps == 2'd2);
        end
        aubf_pkg::NAL_PPS: begin
          res.st.pps = sat_inc(s.pps);
          if ((res.st.pps == 2'd1) && (s.sps == 2'd1)) begin
            res.st.sps_span = r - s.sps_start;
          end
          res.fired = (s.nonidr != 2'd0) || (s.idr != 2'd0);
        end
        aubf_pkg::NAL_AUD: begin
          res.st.aud = sat_inc(s.aud);
          res.fired = res.st.aud == 2'd2;
        end
        default: res.fired = 1'b0;
      endcase
      if (!res.fired) begin
        res.st.skip = 2'd3;
      end
    end
    return res;
  endfunction

  scan_state_t         st_r, st_mid, st_end;
  logic                decided_r;
  logic                out_valid_r;
  aubf_pkg::out_item_t out_data_r, result;
  scan_res_t           res_full, res_tail;
  aubf_pkg::window_t   win_tail;
  aubf_pkg::len_t      r_full, r_tail;
  logic                fired_full, fired_tail, emit;

  assign q_pop    = q_valid && (!out_valid_r || pop);
  assign empty    = !out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    r_full = q_entry.pos - aubf_pkg::len_t'(6);
    r_tail = q_entry.pos - aubf_pkg::len_t'(5);
    for (int i = 0; i < aubf_pkg::WIN_BYTES - 1; i++) begin
      win_tail[i] = q_entry.win[i+1];
    end
    win_tail[aubf_pkg::WIN_BYTES-1] = 8'h00;

    res_full   = scan_at(st_r, q_entry.win, r_full);
    fired_full = q_entry.scan_full && res_full.fired;
    st_mid     = q_entry.scan_full ? res_full.st : st_r;

    // tail scan sees the state left by the full-window scan
    res_tail   = scan_at(st_mid, win_tail, r_tail);
    fired_tail = !fired_full && q_entry.scan_tail && res_tail.fired;
    st_end     = (!fired_full && q_entry.scan_tail) ? res_tail.st : st_mid;

    emit = !decided_r && (fired_full || fired_tail || q_entry.last);

    result.unit_length      = fired_full ? r_full : (fired_tail ? r_tail : q_entry.pos);
    result.found_boundary   = fired_full || fired_tail;
    result.param_set_seen   = st_end.sps != 2'd0;
    result.param_set_offset = (st_end.sps != 2'd0) ? st_end.sps_start : '0;
    result.param_set_length = (st_end.sps != 2'd0) ? st_end.sps_span : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      decided_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        if (q_entry.last) begin
          st_r      <= '0;
          decided_r <= 1'b0;
        end else if (!decided_r) begin
          st_r      <= st_end;
          decided_r <= fired_full || fired_tail;
        end
      end
      if (q_pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_data_r <= result;
    end
  end

endmodule

// ===== src/access_unit_boundary_finder.sv =====
// Top level of the access unit boundary finder: front end, queue, back end.
// Depends on aubf_pkg, aubf_front, aubf_queue and aubf_back.
//
//   channel   ports                          item
//   input     push, full, in_data            one stream byte, last flag
//   result    empty, pop, out_data           one result per call
//
// One byte is taken every cycle while full is low; the front end registers
// the window and position, the back end scans up to two positions per entry.
// A result passes through the queue and the result register to the result ports.
// full rises when QUEUE_DEPTH entries wait, i.e. when the result register is
// held by a stalled pop. Synchronous reset clears window, counts and queue.
`timescale 1ns / 1ps

module access_unit_boundary_finder #(
  parameter int QUEUE_DEPTH = aubf_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  aubf_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output aubf_pkg::out_item_t out_data
);

  logic             q_wr, q_full, q_valid, q_pop;
  aubf_pkg::entry_t q_wr_entry, q_rd_entry;

  assign full = q_full;

  aubf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_entry (q_wr_entry)
  );

  aubf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr),
    .wr_data  (q_wr_entry),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_data  (q_rd_entry)
  );

  aubf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_entry  (q_rd_entry),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

// ===== src/aubf_checker.sv =====
// Port-level checks for the access unit boundary finder, bound to the top.
// Depends on aubf_pkg and access_unit_boundary_finder_defines.svh.
`timescale 1ns / 1ps
`include "access_unit_boundary_finder_defines.svh"

module aubf_port_checks (
  input logic                clk,
  input logic                rst_n,
  input logic                push,
  input logic                full,
  input aubf_pkg::in_item_t  in_data,
  input logic                empty,
  input logic                pop,
  input aubf_pkg::out_item_t out_data
);

  logic stalled;
  logic no_sps_shown;
  logic sps_fields_zero;
  assign stalled         = !empty && !pop;
  assign no_sps_shown    = !empty && !out_data.param_set_seen;
  assign sps_fields_zero = (out_data.param_set_offset == '0) &&
                           (out_data.param_set_length == '0);

  `AUBF_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> empty, "result pending after reset")
  `AUBF_ASSERT_ALWAYS(a_reset_frees, !rst_n |=> !full, "queue full after reset")
  `AUBF_ASSERT(a_stall_holds, stalled |=> !empty && $stable(out_data), "stalled item changed")
  `AUBF_ASSERT(a_no_sps_zero, no_sps_shown |-> sps_fields_zero, "param set fields without SPS")

endmodule

bind access_unit_boundary_finder aubf_port_checks u_aubf_checker (.*);
